### rtl/pvn_pkg.sv
// Package with the widths, codes and tables of the polygon vertex normal block.
`default_nettype none
package pvn_pkg;
  localparam int COORD_BITS = 16;
  localparam int INDEX_BITS = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int OUT_BITS = NORMAL_FRAC_BITS + 2;
  localparam int WORK_FRAC = 30;
  localparam int WB = 36;
  localparam int ITER_BITS = $clog2(CORDIC_ITERATIONS + 1);
  localparam logic [WB-1:0] UNIT_START = WB'(652032874);

  typedef enum logic [2:0] {
    U_IDLE, U_NORM1, U_VEC1, U_NORM2, U_VEC2, U_ROT, U_DONE
  } ustate_t;

  typedef struct packed {
    logic signed [COORD_BITS:0] q1x;
    logic signed [COORD_BITS:0] q1y;
    logic signed [COORD_BITS:0] q2x;
    logic signed [COORD_BITS:0] q2y;
  } job_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] s);
    logic [31:0] r;
    case (s)
      5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E; 5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4; 5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55; 5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F; 5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005; 5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001; default: r = 32'h00000000;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

### rtl/pvn_unit.sv
// Shared CORDIC unit that turns a pair of edge vectors into one unit normal.
`default_nettype none
module pvn_unit import pvn_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire job_t job,
  output logic      busy,
  output logic      done,
  output logic signed [OUT_BITS-1:0] nx,
  output logic signed [OUT_BITS-1:0] ny,
  output logic      degen
);
  ustate_t st_r, st_nxt;
  logic signed [WB-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [31:0] z_r, z_nxt, t1_r, t1_nxt;
  logic [ITER_BITS-1:0] it_r, it_nxt;
  logic neg_r, neg_nxt, degen_r, degen_nxt;
  logic signed [OUT_BITS-1:0] nx_r, nx_nxt, ny_r, ny_nxt;
  job_t job_r, job_nxt;

  logic signed [WB-1:0] ax, ay, mx, dx, dy, bx, by;
  logic [31:0] tab, a, phi, zf;
  logic signed [WB-1:0] rx, ry;

  function automatic logic signed [OUT_BITS-1:0] to_out(input logic signed [WB-1:0] v);
    logic signed [WB-1:0] t;
    t = (v + WB'(1 << (WORK_FRAC - NORMAL_FRAC_BITS - 1))) >>> (WORK_FRAC - NORMAL_FRAC_BITS);
    if (t > WB'(1 << NORMAL_FRAC_BITS)) t = WB'(1 << NORMAL_FRAC_BITS);
    if (t < -WB'(1 << NORMAL_FRAC_BITS)) t = -WB'(1 << NORMAL_FRAC_BITS);
    return t[OUT_BITS-1:0];
  endfunction

  always_comb begin
    ax = x_r[WB-1] ? -x_r : x_r;
    ay = y_r[WB-1] ? -y_r : y_r;
    mx = (ax > ay) ? ax : ay;
    dx = y_r >>> it_r;
    dy = x_r >>> it_r;
    tab = atan_entry(5'(it_r));
    a = z_r - t1_r;
    phi = t1_r + {a[31], a[31:1]} + (a[31] ? 32'h0 : 32'h80000000);
    zf = phi;
    if ($signed(phi) > $signed(32'h40000000) || $signed(phi) < $signed(32'hC0000000))
      zf = phi + 32'h80000000;
    rx = neg_r ? -x_r : x_r;
    ry = neg_r ? -y_r : y_r;
    bx = WB'(job_r.q2x);
    by = WB'(job_r.q2y);
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      U_IDLE: if (start) st_nxt = (job.q1x == '0 && job.q1y == '0) ? U_DONE : U_NORM1;
      default: ;
    endcase
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; t1_nxt = t1_r; it_nxt = it_r;
    neg_nxt = neg_r; degen_nxt = degen_r; nx_nxt = nx_r; ny_nxt = ny_r; job_nxt = job_r;
    unique case (st_r)
      U_IDLE: if (start) begin
        job_nxt = job;
        x_nxt = WB'(job.q1x); y_nxt = WB'(job.q1y);
        z_nxt = '0; it_nxt = '0;
        degen_nxt = (job.q1x == '0 && job.q1y == '0);
        nx_nxt = '0; ny_nxt = '0;
      end
      U_NORM1, U_NORM2: begin
        if (mx < WB'(1 << 29)) begin
          x_nxt = x_r <<< 1; y_nxt = y_r <<< 1;
        end else begin
          if (x_r[WB-1]) begin
            x_nxt = -x_r; y_nxt = -y_r; z_nxt = 32'h80000000;
          end else z_nxt = '0;
          it_nxt = '0;
          st_nxt = (st_r == U_NORM1) ? U_VEC1 : U_VEC2;
        end
      end
      U_VEC1, U_VEC2: begin
        if (it_r == ITER_BITS'(CORDIC_ITERATIONS)) begin
          it_nxt = '0;
          if (st_r == U_VEC1) begin
            t1_nxt = z_r;
            if (job_r.q2x == '0 && job_r.q2y == '0) begin
              z_nxt = z_r; st_nxt = U_ROT;
              x_nxt = UNIT_START; y_nxt = '0; neg_nxt = 1'b0;
            end else begin
              x_nxt = bx; y_nxt = by; st_nxt = U_NORM2;
            end
          end else begin
            z_nxt = zf; neg_nxt = (zf != phi);
            x_nxt = UNIT_START; y_nxt = '0; st_nxt = U_ROT;
          end
          if (st_r == U_VEC1 && job_r.q2x == '0 && job_r.q2y == '0) begin
            z_nxt = z_r + 32'h80000000;
            neg_nxt = 1'b0;
            if ($signed(z_nxt) > $signed(32'h40000000) ||
                $signed(z_nxt) < $signed(32'hC0000000)) begin
              z_nxt = z_r; neg_nxt = 1'b1;
            end
          end
        end else begin
          it_nxt = it_r + 1'b1;
          if (y_r > 0) begin
            x_nxt = x_r + dx; y_nxt = y_r - dy; z_nxt = z_r + tab;
          end else begin
            x_nxt = x_r - dx; y_nxt = y_r + dy; z_nxt = z_r - tab;
          end
        end
      end
      U_ROT: begin
        if (it_r == ITER_BITS'(CORDIC_ITERATIONS)) begin
          nx_nxt = to_out(rx); ny_nxt = to_out(ry); st_nxt = U_DONE;
        end else begin
          it_nxt = it_r + 1'b1;
          if (!z_r[31]) begin
            x_nxt = x_r - dx; y_nxt = y_r + dy; z_nxt = z_r - tab;
          end else begin
            x_nxt = x_r + dx; y_nxt = y_r - dy; z_nxt = z_r + tab;
          end
        end
      end
      U_DONE: st_nxt = U_IDLE;
      default: st_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= U_IDLE;
    else st_r <= st_nxt;
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; t1_r <= t1_nxt; it_r <= it_nxt;
    neg_r <= neg_nxt; degen_r <= degen_nxt; nx_r <= nx_nxt; ny_r <= ny_nxt;
    job_r <= job_nxt;
  end

  assign busy = (st_r != U_IDLE);
  assign done = (st_r == U_DONE);
  assign nx = nx_r;
  assign ny = ny_r;
  assign degen = degen_r;
endmodule
`default_nettype wire

### rtl/polygon_vertex_normals_core.sv
// Top level of the polygon vertex normal block: vertex history and result sequencing.
`default_nettype none
// Streams a closed polygon one vertex per item and returns each vertex's unit
// normal in Q1.14 with its index. From vertex 2 on, vertex k yields the normal
// of vertex k-1; the vertex marked last also yields its own normal and that of
// vertex 0. On the single shared CORDIC unit one normal takes two vectoring
// passes, each after prescaling, and a rotation pass; the second vectoring pass
// is skipped when the next vertex coincides with this one, and no pass runs
// when the previous vertex does. Each normal waits in the output register
// until it is taken, and the next one starts only after that. An item yields
// up to three normals, and the next item can be accepted only after the last
// normal of the current item is taken.
module polygon_vertex_normals_core import pvn_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic signed [COORD_BITS-1:0] in_vertex_x,
  input  wire logic signed [COORD_BITS-1:0] in_vertex_y,
  input  wire logic in_last_vertex,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [INDEX_BITS-1:0] out_vertex_index,
  output logic signed [OUT_BITS-1:0] out_normal_x,
  output logic signed [OUT_BITS-1:0] out_normal_y,
  output logic      out_degenerate,
  output logic      out_last_result
);
  logic signed [COORD_BITS-1:0] fx_r, fy_r, sx_r, sy_r, ox_r, oy_r, nwx_r, nwy_r;
  logic signed [COORD_BITS-1:0] vx_r, vy_r;
  logic [INDEX_BITS-1:0] cnt_r, k_r;
  logic [1:0] seen_r, pend_r, step_r;
  logic last_r, act_r, wait_r, ov_r;
  logic [INDEX_BITS-1:0] oi_r;
  logic ol_r, od_r;
  logic signed [OUT_BITS-1:0] onx_r, ony_r;
  job_t job;
  logic start, busy, done, degen;
  logic signed [OUT_BITS-1:0] nx, ny;
  logic signed [COORD_BITS-1:0] px, py, cx, cy, ex, ey;
  logic [INDEX_BITS-1:0] idx;
  logic lst;

  // Selects prev, current and next for the result in this step of the item.
  always_comb begin
    px = ox_r; py = oy_r; cx = nwx_r; cy = nwy_r; ex = vx_r; ey = vy_r;
    idx = k_r - 1'b1; lst = 1'b0;
    if (seen_r == 2'd0) begin
      px = vx_r; py = vy_r; cx = vx_r; cy = vy_r; idx = '0; lst = 1'b1;
    end else if (seen_r == 2'd1) begin
      if (step_r == 2'd0) begin
        px = fx_r; py = fy_r; cx = vx_r; cy = vy_r; ex = fx_r; ey = fy_r; idx = k_r;
      end else begin
        px = vx_r; py = vy_r; cx = fx_r; cy = fy_r; idx = '0; lst = 1'b1;
      end
    end else if (step_r == 2'd1) begin
      px = nwx_r; py = nwy_r; cx = vx_r; cy = vy_r; ex = fx_r; ey = fy_r; idx = k_r;
    end else if (step_r == 2'd2) begin
      px = vx_r; py = vy_r; cx = fx_r; cy = fy_r; ex = sx_r; ey = sy_r;
      idx = '0; lst = 1'b1;
    end
    job.q1x = (COORD_BITS+1)'(px) - (COORD_BITS+1)'(cx);
    job.q1y = (COORD_BITS+1)'(py) - (COORD_BITS+1)'(cy);
    job.q2x = (COORD_BITS+1)'(ex) - (COORD_BITS+1)'(cx);
    job.q2y = (COORD_BITS+1)'(ey) - (COORD_BITS+1)'(cy);
  end

  assign start = act_r && !wait_r && !busy && !ov_r && pend_r != 2'd0;
  assign in_ready = !act_r;

  pvn_unit u_unit (.clk(clk), .rst_n(rst_n), .start(start), .job(job), .busy(busy),
    .done(done), .nx(nx), .ny(ny), .degen(degen));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0; wait_r <= 1'b0; ov_r <= 1'b0; seen_r <= '0; cnt_r <= '0;
      pend_r <= '0; step_r <= '0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      if (in_valid && in_ready) begin
        vx_r <= in_vertex_x; vy_r <= in_vertex_y; last_r <= in_last_vertex;
        k_r <= cnt_r; step_r <= '0; act_r <= 1'b1;
        if (seen_r == 2'd0) pend_r <= in_last_vertex ? 2'd1 : 2'd0;
        else if (seen_r == 2'd1) pend_r <= in_last_vertex ? 2'd2 : 2'd0;
        else pend_r <= in_last_vertex ? 2'd3 : 2'd1;
      end
      if (start) begin
        wait_r <= 1'b1; oi_r <= idx; ol_r <= lst;
      end
      if (done) begin
        wait_r <= 1'b0; ov_r <= 1'b1; onx_r <= nx; ony_r <= ny; od_r <= degen;
        pend_r <= pend_r - 1'b1; step_r <= step_r + 1'b1;
      end
      if (act_r && !wait_r && !ov_r && !busy && pend_r == 2'd0) begin
        act_r <= 1'b0;
        if (seen_r == 2'd0) begin
          fx_r <= vx_r; fy_r <= vy_r;
        end else if (seen_r == 2'd1) begin
          sx_r <= vx_r; sy_r <= vy_r;
        end
        if (last_r) begin
          seen_r <= '0; cnt_r <= '0;
        end else begin
          if (seen_r == 2'd0) begin
            cnt_r <= INDEX_BITS'(1); seen_r <= 2'd1;
          end else begin
            ox_r <= (seen_r == 2'd1) ? fx_r : nwx_r;
            oy_r <= (seen_r == 2'd1) ? fy_r : nwy_r;
            nwx_r <= vx_r; nwy_r <= vy_r;
            cnt_r <= k_r + 1'b1; seen_r <= 2'd2;
          end
        end
      end
    end
  end

  assign out_valid = ov_r;
  assign out_vertex_index = oi_r;
  assign out_normal_x = onx_r;
  assign out_normal_y = ony_r;
  assign out_degenerate = od_r;
  assign out_last_result = ol_r;
endmodule
`default_nettype wire

### sim/tb_polygon_vertex_normals_core.sv
// Testbench for the polygon vertex normal core with its own normal predictor and result checker.
`timescale 1ns / 100ps
module tb_polygon_vertex_normals_core;
  import pvn_pkg::*;

  typedef struct packed {
    logic [INDEX_BITS-1:0] index;
    logic [OUT_BITS-1:0] nx;
    logic [OUT_BITS-1:0] ny;
    logic degenerate;
    logic last;
  } normal_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_BITS-1:0] in_vertex_x = '0;
  logic signed [COORD_BITS-1:0] in_vertex_y = '0;
  logic in_last_vertex = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [INDEX_BITS-1:0] out_vertex_index;
  logic signed [OUT_BITS-1:0] out_normal_x;
  logic signed [OUT_BITS-1:0] out_normal_y;
  logic out_degenerate;
  logic out_last_result;

  normal_t normals_due[$];
  int error_count = 0;
  bit gaps_on = 1'b1;
  int hold_cycles = 0;

  longint first_x, first_y, second_x, second_y;
  longint older_x, older_y, newer_x, newer_y;
  logic [INDEX_BITS-1:0] next_index = '0;
  int verts_seen = 0;

  polygon_vertex_normals_core dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] bin_angle(longint x, longint y);
    longint ax, ay, m, dx, dy;
    logic [31:0] z;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    m = ax > ay ? ax : ay;
    z = '0;
    while (m < (64'sd1 <<< 29)) begin
      x = x * 2; y = y * 2; m = m * 2;
    end
    if (x < 0) begin
      x = -x; y = -y; z = 32'h8000_0000;
    end
    for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_entry(5'(i));
      end else begin
        x -= dx; y += dy; z -= atan_entry(5'(i));
      end
    end
    return z;
  endfunction

  function automatic logic [OUT_BITS-1:0] to_q14(longint v);
    longint lim;
    lim = 64'sd1 <<< NORMAL_FRAC_BITS;
    v = (v + (64'sd1 <<< (WORK_FRAC - NORMAL_FRAC_BITS - 1))) >>> (WORK_FRAC - NORMAL_FRAC_BITS);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return OUT_BITS'(v);
  endfunction

  function automatic normal_t vertex_normal(logic [INDEX_BITS-1:0] idx, longint px, longint py,
                                            longint cx, longint cy, longint nxv, longint nyv,
                                            logic last);
    normal_t r;
    longint q1x, q1y, q2x, q2y, a, x, y, z, dx, dy;
    logic [31:0] t1, phi;
    bit flip;
    q1x = px - cx; q1y = py - cy;
    q2x = nxv - cx; q2y = nyv - cy;
    r.index = idx;
    r.last = last;
    r.nx = '0; r.ny = '0; r.degenerate = 1'b1;
    if (q1x == 0 && q1y == 0) return r;
    t1 = bin_angle(q1x, q1y);
    a = 0;
    if (q2x != 0 || q2y != 0) a = longint'(signed'(bin_angle(q2x, q2y) - t1));
    phi = t1 + 32'(a >>> 1) + (a >= 0 ? 32'h8000_0000 : 32'h0);
    z = longint'(signed'(phi));
    flip = 1'b0;
    if (z > (64'sd1 <<< 30) || z < -(64'sd1 <<< 30)) begin
      z = longint'(signed'(phi + 32'h8000_0000));
      flip = 1'b1;
    end
    x = 652032874; y = 0;
    for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_entry(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(atan_entry(5'(i)));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    r.nx = to_q14(x); r.ny = to_q14(y); r.degenerate = 1'b0;
    return r;
  endfunction

  task automatic track_vertex(longint vx, longint vy, logic last);
    if (verts_seen == 0) begin
      first_x = vx; first_y = vy;
      if (last) begin
        normals_due.push_back(vertex_normal('0, vx, vy, vx, vy, vx, vy, 1'b1));
      end else begin
        next_index = INDEX_BITS'(1); verts_seen = 1;
      end
    end else if (verts_seen == 1) begin
      second_x = vx; second_y = vy;
      if (last) begin
        normals_due.push_back(vertex_normal(next_index, first_x, first_y, vx, vy,
                                            first_x, first_y, 1'b0));
        normals_due.push_back(vertex_normal('0, vx, vy, first_x, first_y, vx, vy, 1'b1));
        next_index = '0; verts_seen = 0;
      end else begin
        older_x = first_x; older_y = first_y; newer_x = vx; newer_y = vy;
        next_index = next_index + 1'b1; verts_seen = 2;
      end
    end else begin
      normals_due.push_back(vertex_normal(next_index - 1'b1, older_x, older_y, newer_x, newer_y,
                                          vx, vy, 1'b0));
      if (last) begin
        normals_due.push_back(vertex_normal(next_index, newer_x, newer_y, vx, vy,
                                            first_x, first_y, 1'b0));
        normals_due.push_back(vertex_normal('0, vx, vy, first_x, first_y,
                                            second_x, second_y, 1'b1));
        next_index = '0; verts_seen = 0;
      end else begin
        older_x = newer_x; older_y = newer_y; newer_x = vx; newer_y = vy;
        next_index = next_index + 1'b1;
      end
    end
  endtask

  task automatic send_vertex(int x, int y, bit last);
    if (gaps_on && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vertex_x <= COORD_BITS'(x);
    in_vertex_y <= COORD_BITS'(y);
    in_last_vertex <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_vertex(longint'(signed'(COORD_BITS'(x))), longint'(signed'(COORD_BITS'(y))), last);
  endtask

  always @(posedge clk) begin
    normal_t want;
    if (rst_n && out_valid && out_ready) begin
      if (normals_due.size() == 0) begin
        $error("unexpected result for vertex %0d", out_vertex_index);
        error_count++;
      end else begin
        want = normals_due.pop_front();
        if (out_vertex_index !== want.index) begin
          $error("vertex_index expected %0d actual %0d", want.index, out_vertex_index);
          error_count++;
        end
        if (out_normal_x !== want.nx) begin
          $error("normal_x expected %0d actual %0d", signed'(want.nx), out_normal_x);
          error_count++;
        end
        if (out_normal_y !== want.ny) begin
          $error("normal_y expected %0d actual %0d", signed'(want.ny), out_normal_y);
          error_count++;
        end
        if (out_degenerate !== want.degenerate) begin
          $error("degenerate expected %0b actual %0b", want.degenerate, out_degenerate);
          error_count++;
        end
        if (out_last_result !== want.last) begin
          $error("last_result expected %0b actual %0b", want.last, out_last_result);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= !(gaps_on && $urandom_range(99) < 9);
    end
  end

  task automatic send_polygon(int n, bit wide);
    int span;
    int x, y;
    span = wide ? 32767 : $urandom_range(2, 300);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(99) < 8) begin
        // Repeating the previous vertex leaves it with no incoming edge.
        send_vertex(x, y, i == n - 1);
      end else begin
        x = wide ? int'($urandom_range(65535)) - 32768 : $urandom_range(2 * span) - span;
        y = wide ? int'($urandom_range(65535)) - 32768 : $urandom_range(2 * span) - span;
        send_vertex(x, y, i == n - 1);
      end
    end
  endtask

  task automatic test_small_polygons;
    send_vertex(5, -7, 1'b1);
    send_vertex(0, 0, 1'b0);
    send_vertex(100, 0, 1'b1);
    send_vertex(-3, 4, 1'b0);
    send_vertex(-3, 4, 1'b1);
  endtask

  task automatic test_shapes;
    send_vertex(0, 0, 1'b0);
    send_vertex(1000, 0, 1'b0);
    send_vertex(1000, 1000, 1'b0);
    send_vertex(0, 1000, 1'b1);
    send_vertex(0, 0, 1'b0);
    send_vertex(0, 1000, 1'b0);
    send_vertex(1000, 0, 1'b1);
  endtask

  task automatic test_extremes;
    send_vertex(-32768, -32768, 1'b0);
    send_vertex(32767, -32768, 1'b0);
    send_vertex(32767, 32767, 1'b0);
    send_vertex(-32768, 32767, 1'b1);
  endtask

  task automatic test_special_edges;
    // A doubled vertex gives the first copy a zero outgoing edge and the second a zero incoming one.
    send_vertex(10, 10, 1'b0);
    send_vertex(50, 10, 1'b0);
    send_vertex(50, 10, 1'b0);
    send_vertex(50, 60, 1'b0);
    send_vertex(30, 35, 1'b0);
    send_vertex(10, 10, 1'b1);
  endtask

  task automatic test_random_polygons(int budget);
    int n;
    while (budget > 0) begin
      n = $urandom_range(99) < 10 ? $urandom_range(1, 2) : $urandom_range(3, 12);
      send_polygon(n, $urandom_range(99) < 40);
      budget -= n;
    end
  endtask

  task automatic test_back_to_back;
    gaps_on = 1'b0;
    test_random_polygons(60);
    gaps_on = 1'b1;
  endtask

  task automatic test_output_backpressure;
    @(posedge clk);
    hold_cycles <= 600;
    send_polygon(10, 1'b0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_small_polygons();
    test_shapes();
    test_extremes();
    test_special_edges();
    test_random_polygons(160);
    test_back_to_back();
    test_output_backpressure();
    test_random_polygons(160);
    in_valid <= 1'b0;
    while (normals_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS polygon_vertex_normals_core");
    end else begin
      $display("FAIL polygon_vertex_normals_core");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("FAIL polygon_vertex_normals_core");
    $finish;
  end
endmodule

### sim.f
rtl/pvn_pkg.sv
rtl/pvn_unit.sv
rtl/polygon_vertex_normals_core.sv
sim/tb_polygon_vertex_normals_core.sv
